[rtl/core/svs_pkg.sv]
// Shared types and constants for the sensor value stabilizer.
`default_nettype none

package svs_pkg;

	// Decimal places the rounding can keep
	localparam int MAX_DECIMALS = 3;

	// Millisecond products of the 16-bit second registers fit in this width
	localparam int MS_W = 26;
	localparam logic [9:0] MS_PER_S = 10'd1000;

	// Agreement count value that marks "no candidate"
	localparam logic [7:0] NO_CAND = 8'hFF;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_DEC     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_VAR      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SILENCE   = 3'd6;

	// Request modes
	localparam logic MODE_PROCESS   = 1'b0;
	localparam logic MODE_MARK_SENT = 1'b1;

	// Decimal settings
	localparam logic [1:0] DEC_ZERO  = 2'd0;
	localparam logic [1:0] DEC_ONE   = 2'd1;
	localparam logic [1:0] DEC_TWO   = 2'd2;
	localparam logic [1:0] DEC_THREE = 2'd3;

	typedef struct packed {
		logic               mode;
		logic [31:0]        now_ms;
		logic               sample_ready;
		logic signed [31:0] sample;
	} svs_in_t;

	typedef struct packed {
		logic               trigger;
		logic signed [31:0] official_value;
		logic               accepted;
		logic               updated;
	} svs_out_t;

	// Request after rounding, as handed to the tracking stage
	typedef struct packed {
		logic               mode;
		logic [31:0]        now_ms;
		logic               sample_ready;
		logic signed [31:0] value;
	} svs_rnd_t;

	typedef struct packed {
		logic [15:0]     read_interval_ms;
		logic [7:0]      stable_needed;
		logic [7:0]      tolerance;
		logic [MS_W-1:0] cooldown_ms;
		logic [1:0]      round_decimals;
		logic [19:0]     send_variation;
		logic [MS_W-1:0] silence_ms;
	} svs_cfg_t;

endpackage

`default_nettype wire

[rtl/core/sensor_value_stabilizer.sv]
// Sensor value stabilizer top level: config registers, rounding pipeline, tracking stage.
// Takes one request per clock when the result side keeps up; a request passes the rounding
// stages (input, 32x32 reciprocal multiply product, result), then the tracking stage,
// which registers its result as it updates candidate, official and time state. A mode 1
// request marks the official value as sent and clears the trigger; a mode 0 request is
// rounded half away from zero and, if it passes the cooldown and read-interval gates with
// sample_ready set, qualified against the candidate. Time differences wrap modulo
// 2^TIME_BITS. Configuration writes take effect at once and belong only to idle periods.
`default_nettype none

module sensor_value_stabilizer #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [svs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [svs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire svs_pkg::svs_in_t               req_data,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output svs_pkg::svs_out_t                   res_data
);

	svs_pkg::svs_cfg_t cfg;
	svs_pkg::svs_rnd_t rnd;
	logic              rnd_valid;
	logic              rnd_ready;

	svs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	svs_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.in_data   (req_data),
		.out_valid (rnd_valid),
		.out_ready (rnd_ready),
		.out_data  (rnd)
	);

	svs_track #(
		.TIME_BITS (TIME_BITS)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (rnd_valid),
		.item_ready (rnd_ready),
		.item       (rnd),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res_data)
	);

endmodule

`default_nettype wire

[rtl/core/svs_cfg.sv]
// Configuration registers; second counts are held pre-scaled to milliseconds.
`default_nettype none

module svs_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [svs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [svs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output svs_pkg::svs_cfg_t                       cfg
);

	svs_pkg::svs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_interval_ms <= 16'd1000;
			cfg_q.stable_needed    <= 8'd1;
			cfg_q.tolerance        <= 8'd0;
			cfg_q.cooldown_ms      <= '0;
			cfg_q.round_decimals   <= svs_pkg::DEC_ONE;
			cfg_q.send_variation   <= 20'd1000;
			cfg_q.silence_ms       <= svs_pkg::MS_W'(900000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				svs_pkg::REG_READ_INTERVAL: cfg_q.read_interval_ms <= cfg_wdata[15:0];
				svs_pkg::REG_STABLE_NEEDED: cfg_q.stable_needed <= cfg_wdata[7:0];
				svs_pkg::REG_TOLERANCE:     cfg_q.tolerance <= cfg_wdata[7:0];
				svs_pkg::REG_COOLDOWN: begin
					cfg_q.cooldown_ms <= svs_pkg::MS_W'(cfg_wdata[15:0])
						* svs_pkg::MS_W'(svs_pkg::MS_PER_S);
				end
				svs_pkg::REG_ROUND_DEC:     cfg_q.round_decimals <= cfg_wdata[1:0];
				svs_pkg::REG_SEND_VAR:      cfg_q.send_variation <= cfg_wdata[19:0];
				svs_pkg::REG_MAX_SILENCE: begin
					cfg_q.silence_ms <= svs_pkg::MS_W'(cfg_wdata[15:0])
						* svs_pkg::MS_W'(svs_pkg::MS_PER_S);
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/core/svs_round.sv]
// Three-stage rounding pipeline: half away from zero to the configured decimals.
`default_nettype none

module svs_round (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire svs_pkg::svs_cfg_t  cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire svs_pkg::svs_in_t   in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output svs_pkg::svs_rnd_t       out_data
);

	// Reciprocal constants for unsigned 32-bit division by 1000, 100 and 10
	localparam logic [31:0] MAGIC_1000 = 32'h10624DD3;
	localparam logic [31:0] MAGIC_100  = 32'h51EB851F;
	localparam logic [31:0] MAGIC_10   = 32'hCCCCCCCD;
	localparam int SH_1000 = 38;
	localparam int SH_100  = 37;
	localparam int SH_10   = 35;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	svs_pkg::svs_in_t in_s1;

	logic [1:0]  dec;
	logic [31:0] mag;
	logic [31:0] half;
	logic [31:0] magic;
	logic [31:0] num;
	logic [63:0] prod;

	logic [63:0] prod_s2;
	logic [31:0] num_s2;
	logic        neg_s2;
	logic        mode_s2;
	logic [31:0] now_s2;
	logic        sready_s2;

	logic [31:0] quo;
	logic [33:0] rnd;
	logic [31:0] value;

	svs_pkg::svs_rnd_t rnd_s3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Clamp decimals, take magnitude, add half a step, multiply by reciprocal
	always_comb begin
		dec = (cfg.round_decimals > 2'(svs_pkg::MAX_DECIMALS))
			? 2'(svs_pkg::MAX_DECIMALS) : cfg.round_decimals;
		mag = in_s1.sample[31] ? (32'd0 - 32'(in_s1.sample)) : 32'(in_s1.sample);
		unique case (dec)
			svs_pkg::DEC_ZERO: begin
				half  = 32'd500;
				magic = MAGIC_1000;
			end
			svs_pkg::DEC_ONE: begin
				half  = 32'd50;
				magic = MAGIC_100;
			end
			svs_pkg::DEC_TWO: begin
				half  = 32'd5;
				magic = MAGIC_10;
			end
			default: begin
				half  = 32'd0;
				magic = 32'd0;
			end
		endcase
		num  = mag + half;
		prod = 64'(num) * 64'(magic);
	end

	// Scale quotient back up, restore sign, saturate to 32 bits
	always_comb begin
		unique case (dec)
			svs_pkg::DEC_ZERO: begin
				quo = 32'(prod_s2[63:SH_1000]);
				rnd = 34'(quo) * 34'd1000;
			end
			svs_pkg::DEC_ONE: begin
				quo = 32'(prod_s2[63:SH_100]);
				rnd = 34'(quo) * 34'd100;
			end
			svs_pkg::DEC_TWO: begin
				quo = 32'(prod_s2[63:SH_10]);
				rnd = 34'(quo) * 34'd10;
			end
			default: begin
				quo = num_s2;
				rnd = 34'(quo);
			end
		endcase
		if (!neg_s2) begin
			value = (rnd > 34'h07FFFFFFF) ? 32'h7FFFFFFF : rnd[31:0];
		end else begin
			value = (rnd > 34'h080000000) ? 32'h80000000 : (32'd0 - rnd[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			in_s1 <= in_data;
		end
		if (v_s1 && rdy_s2) begin
			prod_s2   <= prod;
			num_s2    <= num;
			neg_s2    <= in_s1.sample[31];
			mode_s2   <= in_s1.mode;
			now_s2    <= in_s1.now_ms;
			sready_s2 <= in_s1.sample_ready;
		end
		if (v_s2 && rdy_s3) begin
			rnd_s3.mode         <= mode_s2;
			rnd_s3.now_ms       <= now_s2;
			rnd_s3.sample_ready <= sready_s2;
			rnd_s3.value        <= $signed(value);
		end
	end

	assign out_valid = v_s3;
	assign out_data  = rnd_s3;

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy_s3) |=> (v_s2 && $stable(prod_s2)))
		else $error("stalled product stage lost its contents");

endmodule

`default_nettype wire

[rtl/core/svs_track.sv]
// Time gates, candidate tracking, official value and send trigger, with result register.
`default_nettype none

module svs_track #(
	parameter int TIME_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire svs_pkg::svs_cfg_t  cfg,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire svs_pkg::svs_rnd_t  item,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output svs_pkg::svs_out_t       res
);

	localparam int CMP_W = (TIME_BITS > svs_pkg::MS_W) ? TIME_BITS : svs_pkg::MS_W;
	localparam logic [TIME_BITS-1:0] TIME_HALF = TIME_BITS'({(TIME_BITS-1){1'b1}});

	logic [TIME_BITS-1:0] last_read_q, last_upd_q, last_send_q;
	logic signed [31:0]   cand_q, official_q, sent_q;
	logic [7:0]           agree_q;
	logic                 pending_q;

	logic [TIME_BITS-1:0] last_read_n, last_upd_n, last_send_n;
	logic signed [31:0]   cand_n, official_n, sent_n;
	logic [7:0]           agree_n;
	logic                 pending_n;

	svs_pkg::svs_out_t res_q;
	logic              res_valid_q;

	logic                 fire;
	logic [TIME_BITS-1:0] nowt, d_upd, d_read, d_send;
	logic                 gate_cool, gate_read, silence;
	logic [7:0]           need;
	logic [32:0]          diff, abs_diff;
	logic [31:0]          abs_cand;
	logic [42:0]          dev, lim;
	logic                 disagree;
	logic                 proceed;
	logic [7:0]           cnt;
	logic [32:0]          sdiff, abs_sdiff;
	logic                 accepted, updated;

	assign item_ready = !res_valid_q || res_ready;
	assign fire       = item_valid && item_ready;

	always_comb begin
		nowt      = TIME_BITS'(item.now_ms);
		d_upd     = nowt - last_upd_q;
		d_read    = nowt - last_read_q;
		d_send    = nowt - last_send_q;
		gate_cool = CMP_W'(d_upd) >= CMP_W'(cfg.cooldown_ms);
		gate_read = CMP_W'(d_read) >= CMP_W'(cfg.read_interval_ms);
		silence   = CMP_W'(d_send) >= CMP_W'(cfg.silence_ms);
		need      = (cfg.stable_needed == 8'd0) ? 8'd1 : cfg.stable_needed;

		// Relative tolerance: |cand - s| * 1000 > |cand| * tol
		diff     = {cand_q[31], cand_q} - {item.value[31], item.value};
		abs_diff = diff[32] ? (33'd0 - diff) : diff;
		abs_cand = cand_q[31] ? (32'd0 - 32'(cand_q)) : 32'(cand_q);
		dev      = 43'(abs_diff) * 43'(svs_pkg::MS_PER_S);
		lim      = 43'(abs_cand) * 43'(cfg.tolerance);
		disagree = dev > lim;

		last_read_n = last_read_q;
		last_upd_n  = last_upd_q;
		last_send_n = last_send_q;
		cand_n      = cand_q;
		official_n  = official_q;
		sent_n      = sent_q;
		agree_n     = agree_q;
		pending_n   = pending_q;
		accepted    = 1'b0;
		updated     = 1'b0;
		proceed     = 1'b1;
		cnt         = agree_q;
		sdiff       = '0;
		abs_sdiff   = '0;

		if (item.mode == svs_pkg::MODE_MARK_SENT) begin
			pending_n   = 1'b0;
			sent_n      = official_q;
			last_send_n = nowt;
		end else if (gate_cool && gate_read && item.sample_ready) begin
			accepted    = 1'b1;
			last_read_n = nowt;
			// Start a new candidate when none is held or the sample strays
			if (agree_q == svs_pkg::NO_CAND || disagree) begin
				cand_n  = item.value;
				cnt     = 8'd0;
				proceed = (need <= 8'd1);
			end
			if (proceed) begin
				cnt = cnt + 8'd1;
			end
			if (proceed && (cnt >= need - 8'd1)) begin
				agree_n    = svs_pkg::NO_CAND;
				official_n = cand_n;
				last_upd_n = nowt;
				updated    = 1'b1;
				sdiff      = {cand_n[31], cand_n} - {sent_q[31], sent_q};
				abs_sdiff  = sdiff[32] ? (33'd0 - sdiff) : sdiff;
				if ((abs_sdiff >= 33'(cfg.send_variation)) || silence) begin
					pending_n = 1'b1;
				end
			end else begin
				agree_n = cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_read_q <= TIME_HALF;
			last_upd_q  <= TIME_HALF;
			last_send_q <= TIME_HALF;
			cand_q      <= '0;
			official_q  <= -32'sd1000;
			sent_q      <= '0;
			agree_q     <= svs_pkg::NO_CAND;
			pending_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				res_valid_q <= item_valid;
			end
			if (fire) begin
				last_read_q <= last_read_n;
				last_upd_q  <= last_upd_n;
				last_send_q <= last_send_n;
				cand_q      <= cand_n;
				official_q  <= official_n;
				sent_q      <= sent_n;
				agree_q     <= agree_n;
				pending_q   <= pending_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.trigger        <= pending_n;
			res_q.official_value <= official_n;
			res_q.accepted       <= accepted;
			res_q.updated        <= updated;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_upd_needs_acc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (!res_q.updated || res_q.accepted))
		else $error("update reported without an accepted sample");

	a_mark_sent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.mode == svs_pkg::MODE_MARK_SENT) |=>
		(!res_q.trigger && !res_q.accepted && !res_q.updated
			&& sent_q == $past(official_q)))
		else $error("mark-sent request did not clear the trigger");

	a_upd_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && updated) |=>
		(agree_q == svs_pkg::NO_CAND && res_q.official_value == cand_q
			&& official_q == cand_q))
		else $error("official update left candidate state open");

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the sensor value stabilizer: scoreboard, stimulus and checks.
module testbench;
	import svs_pkg::*;

	// Predicts the result of every request taken by the design and holds the results still owed
	class official_value_tracker;
		int cfg_interval, cfg_need, cfg_tol, cfg_cooldown, cfg_silence;
		longint cfg_var;
		logic [1:0] cfg_dec;
		logic [31:0] last_read, last_update, last_send;
		longint cand, official, sent;
		logic [7:0] agree;
		bit pending;
		svs_out_t want_results[$];
		int unsigned fails;

		function new();
			cfg_interval = 1000;
			cfg_need = 1;
			cfg_tol = 0;
			cfg_cooldown = 0;
			cfg_dec = DEC_ONE;
			cfg_var = 1000;
			cfg_silence = 900;
			last_read = 32'h7FFF_FFFF;
			last_update = 32'h7FFF_FFFF;
			last_send = 32'h7FFF_FFFF;
			cand = 0;
			agree = NO_CAND;
			official = -1000;
			sent = 0;
			pending = 0;
			fails = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_READ_INTERVAL: cfg_interval = int'(val[15:0]);
				REG_STABLE_NEEDED: cfg_need = int'(val[7:0]);
				REG_TOLERANCE:     cfg_tol = int'(val[7:0]);
				REG_COOLDOWN:      cfg_cooldown = int'(val[15:0]);
				REG_ROUND_DEC:     cfg_dec = val[1:0];
				REG_SEND_VAR:      cfg_var = longint'(val[19:0]);
				REG_MAX_SILENCE:   cfg_silence = int'(val[15:0]);
				default: ;
			endcase
		endfunction

		// Round half away from zero to the kept decimals, then saturate to 32 bits
		function longint round_reading(logic signed [31:0] v);
			longint q, m, r;
			case (cfg_dec)
				DEC_ZERO: q = 1000;
				DEC_ONE:  q = 100;
				DEC_TWO:  q = 10;
				default:  q = 1;
			endcase
			m = (v < 0) ? -longint'(v) : longint'(v);
			r = ((m + q / 2) / q) * q;
			if (v < 0)
				r = -r;
			if (r > 64'sd2147483647)
				r = 64'sd2147483647;
			if (r < -64'sd2147483648)
				r = -64'sd2147483648;
			return r;
		endfunction

		function svs_out_t step_stabilizer(svs_in_t r);
			svs_out_t o;
			logic [31:0] since_upd, since_read, since_send;
			longint s, gap, mag, moved;
			int need, agreed;
			bit proceed;
			o = '0;
			since_upd = r.now_ms - last_update;
			since_read = r.now_ms - last_read;
			if (r.mode == MODE_MARK_SENT) begin
				pending = 0;
				sent = official;
				last_send = r.now_ms;
			end else if (longint'(since_upd) >= longint'(cfg_cooldown) * 1000 &&
					longint'(since_read) >= longint'(cfg_interval) && r.sample_ready) begin
				need = (cfg_need < 1) ? 1 : cfg_need;
				s = round_reading(r.sample);
				proceed = 1;
				o.accepted = 1;
				last_read = r.now_ms;
				gap = cand - s;
				if (gap < 0)
					gap = -gap;
				mag = (cand < 0) ? -cand : cand;
				if (agree == NO_CAND || gap * 1000 > mag * cfg_tol) begin
					cand = s;
					agree = 8'd0;
					if (need > 1)
						proceed = 0;
				end
				if (proceed) begin
					agree = agree + 8'd1;
					agreed = agree;
					if (agreed >= need - 1) begin
						agree = NO_CAND;
						official = cand;
						last_update = r.now_ms;
						o.updated = 1;
						moved = official - sent;
						if (moved < 0)
							moved = -moved;
						since_send = r.now_ms - last_send;
						if (moved >= cfg_var ||
								longint'(since_send) >= longint'(cfg_silence) * 1000)
							pending = 1;
					end
				end
			end
			o.trigger = pending;
			o.official_value = official[31:0];
			return o;
		endfunction

		function void note_request(svs_in_t r);
			want_results.push_back(step_stabilizer(r));
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			fails++;
		endtask

		task check_result(svs_out_t got);
			svs_out_t want;
			if (want_results.size() == 0) begin
				report($sformatf("result %h with no request outstanding", got));
				return;
			end
			want = want_results.pop_front();
			if (got.trigger !== want.trigger)
				report($sformatf("trigger %b, expected %b", got.trigger, want.trigger));
			if (got.official_value !== want.official_value)
				report($sformatf("official_value %0d, expected %0d",
					got.official_value, want.official_value));
			if (got.accepted !== want.accepted)
				report($sformatf("accepted %b, expected %b", got.accepted, want.accepted));
			if (got.updated !== want.updated)
				report($sformatf("updated %b, expected %b", got.updated, want.updated));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic req_valid;
	logic req_ready;
	svs_in_t req_data;
	logic res_valid;
	logic res_ready;
	svs_out_t res_data;

	official_value_tracker book = new();

	int tx_idle_pct = 8;
	int rx_idle_pct = 77;
	bit stall_now = 0;
	int n_items = 0;
	logic [31:0] clock_ms;
	longint level;

	int ph_interval[6] = '{1000, 0, 0, 10, 100, 1};
	int ph_need[6] = '{1, 3, 255, 2, 0, 5};
	int ph_tol[6] = '{0, 50, 255, 0, 255, 10};
	int ph_cooldown[6] = '{0, 0, 0, 65535, 1, 2};
	logic [1:0] ph_dec[6] = '{DEC_ONE, DEC_TWO, DEC_THREE, DEC_ZERO, DEC_THREE, DEC_ONE};
	int ph_var[6] = '{1000, 500, 1000000, 0, 1000000, 12345};
	int ph_silence[6] = '{900, 10, 30, 0, 65535, 5};
	int ph_items[6] = '{200, 220, 400, 150, 150, 200};
	int ph_churn[6] = '{20, 15, 0, 25, 20, 10};

	sensor_value_stabilizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("sensor_value_stabilizer: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			book.check_result(res_data);
	end

	// Result side: random stalls, or one long hold-off when asked for
	initial begin : result_side
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_now) begin
				stall_now = 0;
				res_ready <= 1'b0;
				repeat (60) @(negedge clk);
			end else begin
				res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	function automatic svs_in_t mk_req(logic m, logic [31:0] t, logic rdy, logic [31:0] s);
		svs_in_t r;
		r.mode = m;
		r.now_ms = t;
		r.sample_ready = rdy;
		r.sample = s;
		return r;
	endfunction

	task automatic send_req(input svs_in_t r);
		if (n_items < 440) begin
			tx_idle_pct = 8;
			rx_idle_pct = 77;
		end else if (n_items < 880) begin
			tx_idle_pct = 77;
			rx_idle_pct = 8;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do
			@(posedge clk);
		while (!req_ready);
		book.note_request(r);
		n_items++;
	endtask

	// Hold off the request side until every owed result is back
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (book.want_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		book.set_register(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_phase(input int p);
		cfg_write(REG_READ_INTERVAL, CFG_DATA_W'(ph_interval[p]));
		cfg_write(REG_STABLE_NEEDED, CFG_DATA_W'(ph_need[p]));
		cfg_write(REG_TOLERANCE, CFG_DATA_W'(ph_tol[p]));
		cfg_write(REG_COOLDOWN, CFG_DATA_W'(ph_cooldown[p]));
		cfg_write(REG_ROUND_DEC, CFG_DATA_W'(ph_dec[p]));
		cfg_write(REG_SEND_VAR, CFG_DATA_W'(ph_var[p]));
		cfg_write(REG_MAX_SILENCE, CFG_DATA_W'(ph_silence[p]));
	endtask

	// Advance the timestamp mostly past the gates; keep samples near a level so they agree
	task automatic random_request(input int churn, output svs_in_t r);
		int unsigned pick;
		longint adv, span, mag;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			adv = $urandom_range(0, book.cfg_interval);
		else if (pick < 80)
			adv = book.cfg_interval + $urandom_range(0, 50);
		else if (pick < 90)
			adv = longint'(book.cfg_cooldown) * 1000 + $urandom_range(0, 2000);
		else if (pick < 97)
			adv = longint'(book.cfg_silence) * 1000 + $urandom_range(0, 1000);
		else
			adv = $urandom();
		clock_ms = clock_ms + adv[31:0];
		r.mode = ($urandom_range(0, 99) < 12) ? MODE_MARK_SENT : MODE_PROCESS;
		r.now_ms = clock_ms;
		r.sample_ready = ($urandom_range(0, 99) < 88);
		pick = $urandom_range(0, 99);
		if (pick < churn / 3) begin
			if ($urandom_range(0, 1))
				r.sample = 32'h7FFF_FFFF - $urandom_range(0, 999);
			else
				r.sample = 32'h8000_0000 + $urandom_range(0, 999);
		end else if (pick < churn) begin
			if ($urandom_range(0, 1))
				level = longint'(int'($urandom()));
			else
				level = longint'($urandom_range(0, 20000)) - 10000;
			r.sample = 32'(level);
		end else if (pick < 60) begin
			r.sample = 32'(level);
		end else begin
			mag = (level < 0) ? -level : level;
			span = (mag * book.cfg_tol) / 2000;
			r.sample = 32'(level + longint'($urandom_range(0, 32'(2 * span))) - span);
		end
	endtask

	initial begin : stimulus
		svs_in_t r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req_data = '0;
		level = 1234;
		clock_ms = 32'd4000000;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: gates, rounding, saturation, timestamp wrap, mark-sent
		send_req(mk_req(MODE_PROCESS, 32'd0, 1'b0, 32'd0));
		send_req(mk_req(MODE_PROCESS, 32'd0, 1'b1, 32'd1234));
		send_req(mk_req(MODE_PROCESS, 32'd500, 1'b1, 32'd777));
		send_req(mk_req(MODE_MARK_SENT, 32'd600, 1'b1, -32'sd5));
		send_req(mk_req(MODE_PROCESS, 32'd1600, 1'b1, -32'sd1250));
		send_req(mk_req(MODE_PROCESS, 32'd2600, 1'b1, 32'h7FFF_FFFF));
		send_req(mk_req(MODE_PROCESS, 32'd3600, 1'b1, 32'h8000_0000));
		send_req(mk_req(MODE_MARK_SENT, 32'd3700, 1'b0, 32'd0));
		send_req(mk_req(MODE_PROCESS, 32'd4600, 1'b1, 32'd49));
		send_req(mk_req(MODE_PROCESS, 32'hFFFF_FFFF, 1'b1, 32'd51));
		send_req(mk_req(MODE_PROCESS, 32'd999, 1'b1, -32'sd50));
		send_req(mk_req(MODE_PROCESS, 32'd2000000, 1'b1, -32'sd100));
		drain();

		// Zero stable count, whole units, one second cooldown, zero read interval
		cfg_write(REG_ROUND_DEC, CFG_DATA_W'(DEC_ZERO));
		cfg_write(REG_STABLE_NEEDED, CFG_DATA_W'(0));
		cfg_write(REG_COOLDOWN, CFG_DATA_W'(1));
		cfg_write(REG_READ_INTERVAL, CFG_DATA_W'(0));
		send_req(mk_req(MODE_PROCESS, 32'd3000000, 1'b1, 32'd499));
		send_req(mk_req(MODE_PROCESS, 32'd3000500, 1'b1, 32'd1500));
		send_req(mk_req(MODE_PROCESS, 32'd3001000, 1'b1, -32'sd500));
		send_req(mk_req(MODE_PROCESS, 32'd3002000, 1'b1, 32'h7FFF_FFFF));
		send_req(mk_req(MODE_MARK_SENT, 32'd3002500, 1'b1, 32'hFFFF_FFFF));
		send_req(mk_req(MODE_PROCESS, 32'd3003500, 1'b0, 32'd0));
		drain();

		for (int p = 0; p < 6; p++) begin
			apply_phase(p);
			for (int k = 0; k < ph_items[p]; k++) begin
				if (k == 30)
					stall_now = 1;
				if (k == 60)
					drain();
				random_request(ph_churn[p], r);
				send_req(r);
			end
			drain();
		end

		if (book.fails == 0)
			$display("sensor_value_stabilizer: match");
		else
			$display("sensor_value_stabilizer: mismatch");
		$finish;
	end
endmodule
